[rtl/scpm_pkg.sv]
// ----------------------------------------------------------------------------
// scpm_pkg
// Shared types, constants and table helpers for the crossfade/pan mixer.
// ----------------------------------------------------------------------------
package scpm_pkg;

	localparam logic [1:0] CFG_XFADE = 2'd0;
	localparam logic [1:0] CFG_PAN   = 2'd1;
	localparam logic [1:0] CFG_GAIN  = 2'd2;
	localparam logic [1:0] CFG_MOD   = 2'd3;

	localparam int MOD_GAIN  = 0;
	localparam int MOD_PAN   = 1;
	localparam int MOD_XFADE = 2;

	localparam int CV_BITS  = 24;
	localparam int TRIG_W   = 18;
	localparam int PANW_W   = 19;
	localparam int LANE_CNT_W = 5;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
	localparam longint unsigned LN2_Q30     = 64'd744261118;
	localparam longint          LOG2_10_Q24 = 64'sd27866;
	localparam longint unsigned Q17_ONE     = 64'd131072;

	localparam longint unsigned ROOT_POW_Q30 [8] = '{
		64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
		64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033
	};

	localparam longint unsigned SERIES_DIV [6] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156
	};

	typedef struct packed {
		logic signed [15:0] xfade;
		logic signed [15:0] pan;
		logic signed [13:0] gain;
		logic        [2:0]  mod;
	} cfg_t;

	typedef struct packed {
		logic [TRIG_W-1:0] wa;
		logic [TRIG_W-1:0] wb;
		logic [PANW_W-1:0] lw;
		logic [PANW_W-1:0] rw;
	} weights_t;

	// sine of angle x (q30) by taylor series, rounded to q1.17
	function automatic logic [TRIG_W-1:0] sine_series(input longint unsigned x);
		longint unsigned x2;
		longint unsigned term;
		longint unsigned sum;
		longint unsigned r;
		int k;
		x2 = (x * x) >> 30;
		term = x;
		sum = x;
		for (k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / SERIES_DIV[k-1];
			if ((k % 2) == 1) begin
				sum = sum - term;
			end else begin
				sum = sum + term;
			end
		end
		r = (sum + 64'd4096) >> 13;
		if (r > Q17_ONE) begin
			r = Q17_ONE;
		end
		return r[TRIG_W-1:0];
	endfunction

	// linear gain from log2 value (q24), rounded to q2.17
	function automatic logic [PANW_W-1:0] gain_from_log(input longint l);
		longint unsigned e;
		longint unsigned n;
		longint unsigned f;
		longint unsigned r;
		longint unsigned fl;
		longint unsigned d;
		int k;
		e = unsigned'(l + (64'sd10 <<< 24));
		n = e >> 24;
		f = e & 64'hFFFFFF;
		r = 64'd1 << 30;
		for (k = 1; k <= 8; k++) begin
			if (((f >> (24 - k)) & 64'd1) != 64'd0) begin
				r = (r * ROOT_POW_Q30[k-1]) >> 30;
			end
		end
		fl = f & 64'hFFFF;
		d = (fl * LN2_Q30) >> 24;
		r = r + ((r * d) >> 30);
		r = ((r << n) + (64'd1 << 22)) >> 23;
		if (r > 64'd524287) begin
			r = 64'd524287;
		end
		return r[PANW_W-1:0];
	endfunction

	// position offset 0..32768 from a register value
	function automatic logic [15:0] pos_from_reg(input logic signed [15:0] p);
		logic signed [17:0] t;
		t = 18'(p) + 18'sd16384;
		if (p < -16'sd16384) begin
			t = 18'sd0;
		end else if (p > 16'sd16384) begin
			t = 18'sd32768;
		end
		return t[15:0];
	endfunction

	// position offset 0..32768 from a control voltage
	function automatic logic [15:0] pos_from_cv(input logic signed [CV_BITS-1:0] cv);
		logic [CV_BITS-1:0] c;
		logic [CV_BITS-1:0] t;
		c = cv[CV_BITS-1] ? '0 : {1'b0, cv[CV_BITS-2:0]};
		t = (c + 24'd128) >> 8;
		return t[15:0];
	endfunction

	// gain offset 0..6600 centi-db from a register value
	function automatic logic [12:0] gofs_from_reg(input logic signed [13:0] g);
		logic signed [14:0] t;
		t = 15'(g) + 15'sd6000;
		if (g < -14'sd6000) begin
			t = 15'sd0;
		end else if (g > 14'sd600) begin
			t = 15'sd6600;
		end
		return t[12:0];
	endfunction

	// gain offset 0..6600 centi-db from a control voltage
	function automatic logic [12:0] gofs_from_cv(input logic signed [CV_BITS-1:0] cv);
		logic [35:0] c;
		logic [35:0] t;
		c = cv[CV_BITS-1] ? '0 : 36'(cv[CV_BITS-2:0]);
		t = (c * 36'd6600 + 36'd4194304) >> 23;
		return t[12:0];
	endfunction

endpackage

[rtl/stereo_crossfade_pan_mixer_top.sv]
// ----------------------------------------------------------------------------
// stereo_crossfade_pan_mixer_top
// Constant-power crossfade of two stereo inputs with master gain and pan.
//
// Input channel (in_valid/in_ready) takes one word: a frame of A and B plus
// three control voltages and a block_start flag. Output channel
// (out_valid/out_ready) returns one mixed stereo word per input word.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_data);
// it must be written by the user only while the block is idle, which the
// block does not enforce; it takes effect at the next block start. A word
// without block_start reaches out_valid through the bit-serial lanes
// (18 + 18 + 19 multiplier bits). A word with block_start adds the gain
// sequencer, whose serial divide works on NUM_W bits (23 at the default db
// table depth). in_ready is high only while the core is idle.
// After reset all weights are zero, so output is silence until the first
// block start. A stalled receiver holds the result in the output register;
// the next word is still taken and waits in the core for the slot.
// ----------------------------------------------------------------------------
module stereo_crossfade_pan_mixer_top #(
	parameter int SAMPLE_BITS      = 24,
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int DB_TABLE_DEPTH   = 1024
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  block_start,
	input  logic signed [SAMPLE_BITS-1:0]         a_left,
	input  logic signed [SAMPLE_BITS-1:0]         a_right,
	input  logic signed [SAMPLE_BITS-1:0]         b_left,
	input  logic signed [SAMPLE_BITS-1:0]         b_right,
	input  logic signed [scpm_pkg::CV_BITS-1:0]   gain_cv,
	input  logic signed [scpm_pkg::CV_BITS-1:0]   pan_cv,
	input  logic signed [scpm_pkg::CV_BITS-1:0]   xfade_cv,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [SAMPLE_BITS-1:0]         out_left,
	output logic signed [SAMPLE_BITS-1:0]         out_right,
	input  logic                                  cfg_wr_en,
	input  logic [1:0]                            cfg_index,
	input  logic [15:0]                           cfg_data
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_COEF = 4'b0010,
		ST_MIX  = 4'b0100,
		ST_DONE = 4'b1000
	} top_state_t;

	top_state_t                          state_q;
	scpm_pkg::cfg_t                      cfg_q;
	logic                                coef_go_q;
	logic                                lane_go_q;
	logic                                out_valid_q;
	logic signed [SAMPLE_BITS-1:0]       out_left_q;
	logic signed [SAMPLE_BITS-1:0]       out_right_q;
	logic signed [SAMPLE_BITS-1:0]       al_q;
	logic signed [SAMPLE_BITS-1:0]       ar_q;
	logic signed [SAMPLE_BITS-1:0]       bl_q;
	logic signed [SAMPLE_BITS-1:0]       br_q;
	logic signed [scpm_pkg::CV_BITS-1:0] gain_cv_q;
	logic signed [scpm_pkg::CV_BITS-1:0] pan_cv_q;
	logic signed [scpm_pkg::CV_BITS-1:0] xfade_cv_q;

	logic                          in_fire;
	logic                          out_load;
	logic                          coef_done;
	scpm_pkg::weights_t            weights;
	logic                          lane_done_l;
	logic                          lane_done_r;
	logic signed [SAMPLE_BITS-1:0] lane_res_l;
	logic signed [SAMPLE_BITS-1:0] lane_res_r;

	assign in_ready = (state_q == ST_IDLE);
	assign in_fire = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				scpm_pkg::CFG_XFADE: cfg_q.xfade <= cfg_data;
				scpm_pkg::CFG_PAN:   cfg_q.pan <= cfg_data;
				scpm_pkg::CFG_GAIN:  cfg_q.gain <= cfg_data[13:0];
				scpm_pkg::CFG_MOD:   cfg_q.mod <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			al_q <= a_left;
			ar_q <= a_right;
			bl_q <= b_left;
			br_q <= b_right;
			gain_cv_q <= gain_cv;
			pan_cv_q <= pan_cv;
			xfade_cv_q <= xfade_cv;
		end
		if (out_load) begin
			out_left_q <= lane_res_l;
			out_right_q <= lane_res_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			coef_go_q <= 1'b0;
			lane_go_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			coef_go_q <= in_fire && block_start;
			lane_go_q <= (in_fire && !block_start) || coef_done;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= block_start ? ST_COEF : ST_MIX;
					end
				end
				ST_COEF: begin
					if (coef_done) begin
						state_q <= ST_MIX;
					end
				end
				ST_MIX: begin
					if (lane_done_l) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	scpm_coef #(
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.DB_TABLE_DEPTH   (DB_TABLE_DEPTH)
	) u_coef (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (coef_go_q),
		.cfg      (cfg_q),
		.gain_cv  (gain_cv_q),
		.pan_cv   (pan_cv_q),
		.xfade_cv (xfade_cv_q),
		.done     (coef_done),
		.weights  (weights)
	);

	scpm_lane #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_l (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (lane_go_q),
		.sample_a   (al_q),
		.sample_b   (bl_q),
		.weight_a   (weights.wa),
		.weight_b   (weights.wb),
		.weight_pan (weights.lw),
		.done       (lane_done_l),
		.result     (lane_res_l)
	);

	scpm_lane #(
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_lane_r (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (lane_go_q),
		.sample_a   (ar_q),
		.sample_b   (br_q),
		.weight_a   (weights.wa),
		.weight_b   (weights.wb),
		.weight_pan (weights.rw),
		.done       (lane_done_r),
		.result     (lane_res_r)
	);

	assign out_valid = out_valid_q;
	assign out_left = out_left_q;
	assign out_right = out_right_q;

	a_coef_done_in_coef: assert property (@(posedge clk) disable iff (!arst_n)
		coef_done |-> state_q == ST_COEF)
		else $error("gain sequencer finished outside coef state");

	a_lanes_lockstep: assert property (@(posedge clk) disable iff (!arst_n)
		lane_done_l |-> lane_done_r)
		else $error("left and right lanes out of step");

	a_plain_word_mixes: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !block_start) |=> state_q == ST_MIX)
		else $error("word without block start did not go straight to mixing");

	a_load_sets_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> out_valid)
		else $error("loaded result not presented");

endmodule

[rtl/scpm_coef.sv]
// ----------------------------------------------------------------------------
// scpm_coef
// Gain sequencer: sine and db lookups, serial divide, pan weight multiply.
// ----------------------------------------------------------------------------
module scpm_coef #(
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int DB_TABLE_DEPTH   = 1024
) (
	input  logic                                      clk,
	input  logic                                      arst_n,
	input  logic                                      start,
	input  scpm_pkg::cfg_t                            cfg,
	input  logic signed [scpm_pkg::CV_BITS-1:0]       gain_cv,
	input  logic signed [scpm_pkg::CV_BITS-1:0]       pan_cv,
	input  logic signed [scpm_pkg::CV_BITS-1:0]       xfade_cv,
	output logic                                      done,
	output scpm_pkg::weights_t                        weights
);

	localparam int SA_W  = $clog2(SINE_TABLE_DEPTH);
	localparam int DA_W  = $clog2(DB_TABLE_DEPTH);
	localparam int NUM_W = $clog2(6600 * (DB_TABLE_DEPTH - 1) + 3301);
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int PT_W  = 16 + SA_W + 1;
	localparam int PR_W  = scpm_pkg::TRIG_W + scpm_pkg::PANW_W;

	typedef enum logic [4:0] {
		CS_IDLE = 5'b00001,
		CS_TRIG = 5'b00010,
		CS_DIV  = 5'b00100,
		CS_GAIN = 5'b01000,
		CS_MUL  = 5'b10000
	} coef_state_t;

	logic [scpm_pkg::TRIG_W-1:0] sine_rom [SINE_TABLE_DEPTH];
	logic [scpm_pkg::PANW_W-1:0] db_rom [DB_TABLE_DEPTH];

	for (genvar gi = 0; gi < SINE_TABLE_DEPTH; gi++) begin : g_sine
		localparam longint unsigned XQ =
			(longint'(gi) * scpm_pkg::HALF_PI_Q30) / (SINE_TABLE_DEPTH - 1);
		assign sine_rom[gi] = scpm_pkg::sine_series(XQ);
	end

	for (genvar gi = 0; gi < DB_TABLE_DEPTH; gi++) begin : g_db
		localparam longint LQ =
			((longint'(gi) * 6600 - longint'(6000) * (DB_TABLE_DEPTH - 1))
			* scpm_pkg::LOG2_10_Q24) / (DB_TABLE_DEPTH - 1);
		assign db_rom[gi] = scpm_pkg::gain_from_log(LQ);
	end

	coef_state_t                 state_q;
	logic [CNT_W-1:0]            cnt_q;
	logic [SA_W-1:0]             ix_q;
	logic [SA_W-1:0]             ip_q;
	logic [NUM_W-1:0]            num_q;
	logic [NUM_W-1:0]            quo_q;
	logic [12:0]                 rem_q;
	logic [scpm_pkg::TRIG_W-1:0] sine_q;
	logic [scpm_pkg::TRIG_W-1:0] sin_l_q;
	logic [scpm_pkg::TRIG_W-1:0] sin_r_q;
	logic [scpm_pkg::PANW_W-1:0] db_q;
	logic [PR_W-1:0]             prod_q;
	logic                        done_q;
	scpm_pkg::weights_t          weights_q;

	logic [15:0]      xf_u;
	logic [15:0]      pn_u;
	logic [12:0]      gofs;
	logic [PT_W-1:0]  xf_prod;
	logic [PT_W-1:0]  pn_prod;
	logic [NUM_W-1:0] gnum;
	logic [SA_W-1:0]  sine_addr;
	logic [13:0]      trial;
	logic [PR_W-1:0]  prod_rnd;

	always_comb begin
		xf_u = cfg.mod[scpm_pkg::MOD_XFADE] ? scpm_pkg::pos_from_cv(xfade_cv)
			: scpm_pkg::pos_from_reg(cfg.xfade);
		pn_u = cfg.mod[scpm_pkg::MOD_PAN] ? scpm_pkg::pos_from_cv(pan_cv)
			: scpm_pkg::pos_from_reg(cfg.pan);
		gofs = cfg.mod[scpm_pkg::MOD_GAIN] ? scpm_pkg::gofs_from_cv(gain_cv)
			: scpm_pkg::gofs_from_reg(cfg.gain);
		xf_prod = PT_W'(xf_u) * PT_W'(SINE_TABLE_DEPTH - 1) + PT_W'(16384);
		pn_prod = PT_W'(pn_u) * PT_W'(SINE_TABLE_DEPTH - 1) + PT_W'(16384);
		gnum = NUM_W'(gofs) * NUM_W'(DB_TABLE_DEPTH - 1) + NUM_W'(3300);
		trial = {rem_q, num_q[NUM_W-1]};
		prod_rnd = (prod_q + PR_W'(65536)) >> 17;
		case (cnt_q)
			CNT_W'(0): sine_addr = SA_W'(SINE_TABLE_DEPTH - 1) - ix_q;
			CNT_W'(1): sine_addr = ix_q;
			CNT_W'(2): sine_addr = SA_W'(SINE_TABLE_DEPTH - 1) - ip_q;
			default:   sine_addr = ip_q;
		endcase
	end

	always_ff @(posedge clk) begin
		sine_q <= sine_rom[sine_addr];
		db_q <= db_rom[quo_q[DA_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= CS_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
			weights_q <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				CS_IDLE: begin
					if (start) begin
						ix_q <= xf_prod[15 +: SA_W];
						ip_q <= pn_prod[15 +: SA_W];
						num_q <= gnum;
						rem_q <= '0;
						quo_q <= '0;
						cnt_q <= '0;
						state_q <= CS_TRIG;
					end
				end
				CS_TRIG: begin
					cnt_q <= cnt_q + CNT_W'(1);
					case (cnt_q)
						CNT_W'(1): weights_q.wa <= sine_q;
						CNT_W'(2): weights_q.wb <= sine_q;
						CNT_W'(3): sin_l_q <= sine_q;
						CNT_W'(4): begin
							sin_r_q <= sine_q;
							cnt_q <= '0;
							state_q <= CS_DIV;
						end
						default: ;
					endcase
				end
				CS_DIV: begin
					num_q <= num_q << 1;
					if (trial >= 14'd6600) begin
						rem_q <= 13'(trial - 14'd6600);
						quo_q <= {quo_q[NUM_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[12:0];
						quo_q <= {quo_q[NUM_W-2:0], 1'b0};
					end
					cnt_q <= cnt_q + CNT_W'(1);
					if (cnt_q == CNT_W'(NUM_W - 1)) begin
						cnt_q <= '0;
						state_q <= CS_GAIN;
					end
				end
				CS_GAIN: begin
					state_q <= CS_MUL;
				end
				CS_MUL: begin
					cnt_q <= cnt_q + CNT_W'(1);
					case (cnt_q)
						CNT_W'(0): prod_q <= PR_W'(db_q) * PR_W'(sin_l_q);
						CNT_W'(1): begin
							weights_q.lw <= prod_rnd[scpm_pkg::PANW_W-1:0];
							prod_q <= PR_W'(db_q) * PR_W'(sin_r_q);
						end
						default: begin
							weights_q.rw <= prod_rnd[scpm_pkg::PANW_W-1:0];
							done_q <= 1'b1;
							cnt_q <= '0;
							state_q <= CS_IDLE;
						end
					endcase
				end
				default: state_q <= CS_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign weights = weights_q;

endmodule

[rtl/scpm_lane.sv]
// ----------------------------------------------------------------------------
// scpm_lane
// One channel: bit-serial crossfade mix, then bit-serial pan/gain, saturate.
// ----------------------------------------------------------------------------
module scpm_lane #(
	parameter int SAMPLE_BITS = 24
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic signed [SAMPLE_BITS-1:0]       sample_a,
	input  logic signed [SAMPLE_BITS-1:0]       sample_b,
	input  logic [scpm_pkg::TRIG_W-1:0]         weight_a,
	input  logic [scpm_pkg::TRIG_W-1:0]         weight_b,
	input  logic [scpm_pkg::PANW_W-1:0]         weight_pan,
	output logic                                done,
	output logic signed [SAMPLE_BITS-1:0]       result
);

	localparam int ACC_W = SAMPLE_BITS + 26;
	localparam int CW    = scpm_pkg::LANE_CNT_W;
	localparam logic signed [ACC_W-1:0] HALF_MIX = ACC_W'(64'sd4096);
	localparam logic signed [ACC_W-1:0] HALF_OUT = ACC_W'(64'sd1 <<< 20);
	localparam logic signed [ACC_W-1:0] SAT_HI   = ACC_W'((64'sd1 <<< (SAMPLE_BITS - 1)) - 1);
	localparam logic signed [ACC_W-1:0] SAT_LO   = -SAT_HI - ACC_W'(64'sd1);

	typedef enum logic [3:0] {
		PH_IDLE = 4'b0001,
		PH_A    = 4'b0010,
		PH_B    = 4'b0100,
		PH_C    = 4'b1000
	} lane_phase_t;

	lane_phase_t                   phase_q;
	logic [CW-1:0]                 cnt_q;
	logic signed [ACC_W-1:0]       mcand_q;
	logic [scpm_pkg::PANW_W-1:0]   mplier_q;
	logic signed [ACC_W-1:0]       acc_q;
	logic                          done_q;
	logic signed [SAMPLE_BITS-1:0] result_q;

	logic signed [ACC_W-1:0] acc_add;
	logic signed [ACC_W-1:0] mix_val;
	logic signed [ACC_W-1:0] out_val;
	logic signed [ACC_W-1:0] sat_val;

	always_comb begin
		acc_add = mplier_q[0] ? acc_q + mcand_q : acc_q;
		mix_val = (acc_add + HALF_MIX) >>> 13;
		out_val = (acc_add + HALF_OUT) >>> 21;
		sat_val = out_val;
		if (out_val > SAT_HI) begin
			sat_val = SAT_HI;
		end else if (out_val < SAT_LO) begin
			sat_val = SAT_LO;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (phase_q)
				PH_IDLE: begin
					if (start) begin
						mcand_q <= ACC_W'(sample_a);
						mplier_q <= scpm_pkg::PANW_W'(weight_a);
						acc_q <= '0;
						cnt_q <= '0;
						phase_q <= PH_A;
					end
				end
				PH_A: begin
					acc_q <= acc_add;
					mcand_q <= mcand_q <<< 1;
					mplier_q <= mplier_q >> 1;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(scpm_pkg::TRIG_W - 1)) begin
						mcand_q <= ACC_W'(sample_b);
						mplier_q <= scpm_pkg::PANW_W'(weight_b);
						cnt_q <= '0;
						phase_q <= PH_B;
					end
				end
				PH_B: begin
					acc_q <= acc_add;
					mcand_q <= mcand_q <<< 1;
					mplier_q <= mplier_q >> 1;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(scpm_pkg::TRIG_W - 1)) begin
						mcand_q <= mix_val;
						mplier_q <= weight_pan;
						acc_q <= '0;
						cnt_q <= '0;
						phase_q <= PH_C;
					end
				end
				PH_C: begin
					acc_q <= acc_add;
					mcand_q <= mcand_q <<< 1;
					mplier_q <= mplier_q >> 1;
					cnt_q <= cnt_q + CW'(1);
					if (cnt_q == CW'(scpm_pkg::PANW_W - 1)) begin
						result_q <= sat_val[SAMPLE_BITS-1:0];
						done_q <= 1'b1;
						cnt_q <= '0;
						phase_q <= PH_IDLE;
					end
				end
				default: phase_q <= PH_IDLE;
			endcase
		end
	end

	assign done = done_q;
	assign result = result_q;

endmodule

[tb/tb_stereo_crossfade_pan_mixer_top.sv]
// ----------------------------------------------------------------------------
// tb_stereo_crossfade_pan_mixer_top
// Self-checking bench for the crossfade/pan mixer. A short directed table
// (silence before the first block start, sample and control voltage extremes,
// every register and every modulation source) is followed by about 1950
// random words under four idling patterns and several register settings.
// Each returned word is compared field by field with a bit-exact predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_stereo_crossfade_pan_mixer_top;

	localparam int SB = 24;
	localparam int SDEP = 256;
	localparam int DDEP = 1024;
	localparam logic signed [SB-1:0] SMAX = 24'sh7FFFFF;
	localparam logic signed [SB-1:0] SMIN = -24'sh800000;
	localparam longint unsigned ANG_Q30 = 64'd1686629713;
	localparam longint unsigned LOGE2_Q30 = 64'd744261118;
	localparam longint DB_LOG_Q24 = 64'sd27866;
	localparam longint unsigned ROOTS [8] = '{
		64'd1518500250, 64'd1276901417, 64'd1170923762, 64'd1121280436,
		64'd1097253708, 64'd1085434106, 64'd1079572136, 64'd1076653033
	};
	localparam int N_RANDOM = 1950;

	typedef struct {
		bit                     is_cfg;
		logic [1:0]             idx;
		logic [15:0]            val;
		logic                   bs;
		logic signed [SB-1:0]   al, ar, bl, br;
		logic signed [23:0]     gcv, pcv, xcv;
		bit                     typed;
		logic signed [SB-1:0]   el, er;
	} row_t;

	typedef struct {
		logic signed [SB-1:0] l;
		logic signed [SB-1:0] r;
	} stereo_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic block_start = 1'b0;
	logic signed [SB-1:0] a_left = '0, a_right = '0, b_left = '0, b_right = '0;
	logic signed [23:0] gain_cv = '0, pan_cv = '0, xfade_cv = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SB-1:0] out_left, out_right;
	logic cfg_wr_en = 1'b0;
	logic [1:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;

	stereo_crossfade_pan_mixer_top dut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic signed [15:0] p_xfade, p_pan;
	logic signed [13:0] p_gain;
	logic [2:0] p_mod;
	logic [17:0] w_a, w_b;
	logic [18:0] w_l, w_r;

	stereo_t mix_q[$];
	int errors = 0, n_words = 0, n_results = 0, n_starts = 0, n_writes = 0;
	int idle_pct = 0, stall_pct = 0;
	int hold_req = 0, hold_done = 0, hold_left = 0;

	function automatic longint unsigned sine_q17(int i);
		longint unsigned x, x2, term, acc, r;
		x = longint'(i) * ANG_Q30 / (SDEP - 1);
		x2 = (x * x) >> 30;
		term = x;
		acc = x;
		for (int k = 1; k <= 6; k++) begin
			term = ((term * x2) >> 30) / longint'((2 * k) * (2 * k + 1));
			if (k % 2 == 1) begin
				acc = acc - term;
			end else begin
				acc = acc + term;
			end
		end
		r = (acc + 4096) >> 13;
		return (r > 131072) ? 131072 : r;
	endfunction

	function automatic longint unsigned lin_gain(int i);
		longint num, lg;
		longint unsigned e, n, f, r, fl, d;
		num = longint'(i) * 6600 - longint'(6000) * (DDEP - 1);
		lg = num * DB_LOG_Q24 / (DDEP - 1);
		e = unsigned'(lg + (longint'(10) <<< 24));
		n = e >> 24;
		f = e & 64'hFFFFFF;
		r = 64'd1 << 30;
		for (int k = 1; k <= 8; k++) begin
			if (((f >> (24 - k)) & 1) != 0) begin
				r = (r * ROOTS[k-1]) >> 30;
			end
		end
		fl = f & 64'hFFFF;
		d = (fl * LOGE2_Q30) >> 24;
		r = r + ((r * d) >> 30);
		r = ((r << n) + (64'd1 << 22)) >> 23;
		return (r > 524287) ? 524287 : r;
	endfunction

	function automatic longint clip(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint cv_clamped(logic signed [23:0] cv);
		return clip(longint'(cv), 0, 8388608);
	endfunction

	function automatic int angle_point(longint p);
		p = clip(p, -16384, 16384);
		return int'(((p + 16384) * (SDEP - 1) + 16384) >>> 15);
	endfunction

	function automatic longint rshift_round(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic logic signed [SB-1:0] mix_one(logic signed [SB-1:0] a,
			logic signed [SB-1:0] b, logic [18:0] w);
		longint m, v;
		m = rshift_round(longint'(a) * longint'(w_a) + longint'(b) * longint'(w_b), 13);
		v = rshift_round(m * longint'(w), 21);
		return SB'(clip(v, -8388608, 8388607));
	endfunction

	function automatic stereo_t mix_frame(row_t f);
		longint xf, pn, g;
		int ix, ip;
		longint unsigned gl;
		stereo_t o;
		if (f.bs) begin
			xf = p_mod[scpm_pkg::MOD_XFADE] ? -16384 + ((cv_clamped(f.xcv) + 128) >>> 8)
				: longint'(p_xfade);
			ix = angle_point(xf);
			w_a = 18'(sine_q17(SDEP - 1 - ix));
			w_b = 18'(sine_q17(ix));
			g = p_mod[scpm_pkg::MOD_GAIN]
				? -6000 + ((cv_clamped(f.gcv) * 6600 + 4194304) >>> 23)
				: longint'(p_gain);
			g = clip(g, -6000, 600);
			gl = lin_gain(int'(((g + 6000) * (DDEP - 1) + 3300) / 6600));
			pn = p_mod[scpm_pkg::MOD_PAN] ? -16384 + ((cv_clamped(f.pcv) + 128) >>> 8)
				: longint'(p_pan);
			ip = angle_point(pn);
			w_l = 19'((gl * sine_q17(SDEP - 1 - ip) + 65536) >> 17);
			w_r = 19'((gl * sine_q17(ip) + 65536) >> 17);
		end
		o.l = mix_one(f.al, f.bl, w_l);
		o.r = mix_one(f.ar, f.br, w_r);
		return o;
	endfunction

	function automatic row_t frame(logic bs, logic signed [SB-1:0] al, ar, bl, br,
			logic signed [23:0] gcv, pcv, xcv);
		row_t r;
		r = '{default: '0};
		r.bs = bs;
		r.al = al;
		r.ar = ar;
		r.bl = bl;
		r.br = br;
		r.gcv = gcv;
		r.pcv = pcv;
		r.xcv = xcv;
		return r;
	endfunction

	function automatic row_t reg_row(logic [1:0] idx, logic [15:0] val);
		row_t r;
		r = '{default: '0};
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.val = val;
		return r;
	endfunction

	function automatic logic signed [23:0] rnd_word();
		case ($urandom_range(5))
			0: return SMAX;
			1: return SMIN;
			2: return 24'(-$urandom_range(40000));
			default: return 24'($urandom);
		endcase
	endfunction

	function automatic logic signed [23:0] rnd_cv();
		case ($urandom_range(5))
			0: return 24'sd0;
			1: return SMAX;
			2: return 24'($urandom);
			default: return 24'($urandom_range(8388607));
		endcase
	endfunction

	task automatic drain();
		while (mix_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (100) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [15:0] val);
		drain();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		case (idx)
			scpm_pkg::CFG_XFADE: p_xfade = val;
			scpm_pkg::CFG_PAN:   p_pan = val;
			scpm_pkg::CFG_GAIN:  p_gain = val[13:0];
			scpm_pkg::CFG_MOD:   p_mod = val[2:0];
			default: ;
		endcase
		n_writes++;
	endtask

	task automatic send_word(row_t f);
		stereo_t o;
		in_valid <= 1'b1;
		block_start <= f.bs;
		a_left <= f.al;
		a_right <= f.ar;
		b_left <= f.bl;
		b_right <= f.br;
		gain_cv <= f.gcv;
		pan_cv <= f.pcv;
		xfade_cv <= f.xcv;
		do @(posedge clk); while (!in_ready);
		o = mix_frame(f);
		if (f.typed) begin
			o.l = f.el;
			o.r = f.er;
		end
		mix_q = {mix_q, o};
		n_words++;
		n_starts += f.bs;
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
	endtask

	task automatic idle_input();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	// receiver side: random stalls plus one long hold-off
	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_ready <= 1'b0;
			hold_left <= hold_left - 1;
		end else if (hold_req != hold_done) begin
			hold_done <= hold_done + 1;
			hold_left <= 600;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= stall_pct);
		end
	end

	always @(posedge clk) begin
		stereo_t e;
		if (out_valid && out_ready) begin
			n_results++;
			if (mix_q.size() == 0) begin
				errors++;
				$error("unexpected word: out_left %0d out_right %0d", out_left, out_right);
			end else begin
				e = mix_q.pop_front();
				if (out_left !== e.l) begin
					errors++;
					$error("out_left expected %0d actual %0d", e.l, out_left);
				end
				if (out_right !== e.r) begin
					errors++;
					$error("out_right expected %0d actual %0d", e.r, out_right);
				end
			end
		end
	end

	initial begin
		#40_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		row_t dir[$];
		row_t r;
		int ph;
		p_xfade = '0;
		p_pan = '0;
		p_gain = '0;
		p_mod = '0;
		w_a = '0;
		w_b = '0;
		w_l = '0;
		w_r = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);

		// silence until the first block start
		r = frame(1'b0, SMAX, SMIN, SMAX, SMIN, SMAX, SMAX, SMAX);
		r.typed = 1'b1;
		dir = {dir, r};
		r = frame(1'b0, SMIN, SMAX, SMIN, SMAX, SMIN, SMIN, SMIN);
		r.typed = 1'b1;
		dir = {dir, r};
		// center everything, unity gain, full-scale samples saturate
		dir = {dir, frame(1'b1, SMAX, SMAX, SMAX, SMAX, '0, '0, '0)};
		dir = {dir, frame(1'b0, SMIN, SMIN, SMIN, SMIN, '0, '0, '0)};
		dir = {dir, frame(1'b0, 24'sd1, -24'sd1, 24'sd0, 24'sd0, '0, '0, '0)};
		// register extremes, out of range values saturate
		dir = {dir, reg_row(scpm_pkg::CFG_XFADE, 16'h8000)};
		dir = {dir, reg_row(scpm_pkg::CFG_PAN, 16'h7FFF)};
		dir = {dir, reg_row(scpm_pkg::CFG_GAIN, 16'(14'sd600))};
		dir = {dir, frame(1'b0, SMAX, SMAX, SMIN, SMIN, '0, '0, '0)};
		dir = {dir, frame(1'b1, SMAX, SMAX, SMIN, SMIN, '0, '0, '0)};
		dir = {dir, reg_row(scpm_pkg::CFG_XFADE, 16'(16'sd16384))};
		dir = {dir, reg_row(scpm_pkg::CFG_PAN, 16'(-16'sd16384))};
		dir = {dir, reg_row(scpm_pkg::CFG_GAIN, 16'h2000)};
		dir = {dir, frame(1'b1, SMIN, SMAX, SMAX, SMIN, '0, '0, '0)};
		dir = {dir, reg_row(scpm_pkg::CFG_GAIN, 16'(-14'sd6000))};
		dir = {dir, frame(1'b1, SMAX, SMIN, SMAX, SMIN, '0, '0, '0)};
		// each modulation source, then all, with cv below zero, zero and full
		dir = {dir, reg_row(scpm_pkg::CFG_MOD, 16'(1 << scpm_pkg::MOD_GAIN))};
		dir = {dir, frame(1'b1, SMAX, SMAX, SMAX, SMAX, SMAX, SMIN, SMIN)};
		dir = {dir, reg_row(scpm_pkg::CFG_MOD, 16'(1 << scpm_pkg::MOD_PAN))};
		dir = {dir, frame(1'b1, SMAX, SMIN, SMAX, SMIN, SMIN, SMAX, '0)};
		dir = {dir, reg_row(scpm_pkg::CFG_MOD, 16'(1 << scpm_pkg::MOD_XFADE))};
		dir = {dir, frame(1'b1, SMIN, SMIN, SMAX, SMAX, '0, '0, SMAX)};
		dir = {dir, reg_row(scpm_pkg::CFG_MOD, 16'hFFFF)};
		dir = {dir, frame(1'b1, SMAX, SMAX, SMAX, SMAX, SMIN, SMIN, SMIN)};
		dir = {dir, frame(1'b1, SMAX, SMIN, SMIN, SMAX, '0, 24'sd4194304, SMAX)};

		foreach (dir[i]) begin
			if (dir[i].is_cfg) begin
				idle_input();
				write_reg(dir[i].idx, dir[i].val);
			end else begin
				send_word(dir[i]);
			end
		end

		for (int n = 0; n < N_RANDOM; n++) begin
			ph = n * 4 / N_RANDOM;
			if (n % 100 == 0) begin
				// settle, then pick new registers between bursts
				idle_input();
				case (ph)
					0: begin idle_pct = 0;  stall_pct = 0;  end
					1: begin idle_pct = 88; stall_pct = 0;  end
					2: begin idle_pct = 0;  stall_pct = 88; end
					default: begin idle_pct = 25; stall_pct = 25; end
				endcase
				if ((n / 100) % 5 == 4) begin
					idle_pct = 0;
					stall_pct = 0;
				end
				write_reg(scpm_pkg::CFG_XFADE, $urandom_range(1) ? 16'($urandom)
					: 16'(int'($urandom_range(32768)) - 16384));
				write_reg(scpm_pkg::CFG_PAN, $urandom_range(1) ? 16'($urandom)
					: 16'(int'($urandom_range(32768)) - 16384));
				write_reg(scpm_pkg::CFG_GAIN, $urandom_range(1) ? 16'($urandom)
					: 16'(int'($urandom_range(6600)) - 6000));
				write_reg(scpm_pkg::CFG_MOD, 16'($urandom));
			end
			if (n == 50) begin
				hold_req++;
			end
			r = frame($urandom_range(7) == 0 || n % 100 == 0, rnd_word(), rnd_word(),
				rnd_word(), rnd_word(), rnd_cv(), rnd_cv(), rnd_cv());
			send_word(r);
		end
		idle_input();

		drain();
		$display("covered %0d words (%0d block starts) and %0d register writes",
			n_words, n_starts, n_writes);
		$display("checked %0d returned words, %0d mismatches", n_results, errors);
		if (errors == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

[files.f]
rtl/scpm_pkg.sv
rtl/scpm_coef.sv
rtl/scpm_lane.sv
rtl/stereo_crossfade_pan_mixer_top.sv
tb/tb_stereo_crossfade_pan_mixer_top.sv
